// ----- src/affinity_table_with_fifo_replace_assert.svh -----
// ----------------------------------------------------------------------------
// Affinity table assertion macros
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef AFFINITY_TABLE_WITH_FIFO_REPLACE_ASSERT_SVH
`define AFFINITY_TABLE_WITH_FIFO_REPLACE_ASSERT_SVH
`ifndef SYNTHESIS
`define AFT_ASSERT_NOW(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define AFT_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define AFT_ASSERT_NOW(lbl, clk, rst_n, a, b)
`define AFT_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ----- src/aft_pkg.sv -----
// ----------------------------------------------------------------------------
// Affinity table package
// Table sizes, derived widths and sequencer constants.
// ----------------------------------------------------------------------------
package aft_pkg;
    localparam int ENT_DEPTH = 32;
    localparam int EDG_DEPTH = 64;
    localparam int ENT_AW    = $clog2(ENT_DEPTH);
    localparam int EDG_AW    = $clog2(EDG_DEPTH);
    localparam int ENT_CW    = $clog2(ENT_DEPTH + 1);
    localparam int EDG_CW    = $clog2(EDG_DEPTH + 1);
    localparam int SCAN_W    = (ENT_CW > EDG_CW) ? ENT_CW : EDG_CW;

    localparam logic [16:0] STEP_GAIN = 17'd25;

    localparam logic [1:0] OP_OBSERVE = 2'd0;
    localparam logic [1:0] OP_ENGAGE  = 2'd1;
    localparam logic [1:0] OP_ATTRACT = 2'd2;
    localparam logic [1:0] OP_BOOST   = 2'd3;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ESCAN = 2'd1;
    localparam logic [1:0] S_GSCAN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    typedef logic [16:0] t_val;
endpackage

// ----- src/affinity_table_with_fifo_replace.sv -----
// ----------------------------------------------------------------------------
// Affinity table with FIFO replacement
// Entry and edge tables scanned one slot per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// One request at a time. Entry and edge scans make one compare per cycle
// behind the registered table read, over the filled slots of their table;
// a boost element may run an entry lookup, an edge scan for its shown item
// and the emit of its total, an attract an edge scan, an observe an entry scan.
// The result of a query sits in an output register while the next request
// is taken. boost_cap may be written at any idle time.
module affinity_table_with_fifo_replace import aft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_query_key,
    input  logic [31:0] i_target_file,
    input  logic [31:0] i_target_index,
    input  logic [31:0] i_source_file,
    input  logic [31:0] i_source_index,
    input  logic [31:0] i_shown_word,
    input  logic        i_has_shown,
    input  logic        i_first_of_query,
    input  logic        i_last_of_query,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_boost_total
);
    logic [15:0] r_cap;
    logic [1:0]  r_state, n_state;
    logic [1:0]  r_op;
    logic [63:0] r_key;
    logic [31:0] r_tf, r_tx, r_sf, r_sx;
    logic [31:0] r_wf, r_wx;
    logic        r_has, r_last;
    logic [SCAN_W-1:0] r_ridx, n_ridx;
    logic        r_pv, n_pv;
    logic [SCAN_W-1:0] r_pidx, n_pidx;
    logic [ENT_CW-1:0] r_ent_cnt, n_ent_cnt;
    logic [ENT_AW-1:0] r_ent_pos, n_ent_pos;
    logic [EDG_CW-1:0] r_edg_cnt, n_edg_cnt;
    logic [EDG_AW-1:0] r_edg_pos, n_edg_pos;
    t_val        r_total, n_total;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out, n_out;

    logic [63:0] ent_key  [ENT_DEPTH];
    logic [31:0] ent_file [ENT_DEPTH];
    logic [31:0] ent_idx  [ENT_DEPTH];
    t_val        ent_boost[ENT_DEPTH];
    logic [31:0] edg_ff [EDG_DEPTH];
    logic [31:0] edg_fx [EDG_DEPTH];
    logic [31:0] edg_tf [EDG_DEPTH];
    logic [31:0] edg_tx [EDG_DEPTH];
    t_val        edg_w  [EDG_DEPTH];

    logic [63:0] r_rk;
    logic [31:0] r_rf, r_rx;
    t_val        r_rb;
    logic [31:0] r_gff, r_gfx, r_gtf, r_gtx;
    t_val        r_gw;

    logic              ent_we, ent_bwe, edg_we, edg_wwe;
    logic [ENT_AW-1:0] ent_wa;
    logic [EDG_AW-1:0] edg_wa;
    t_val              ent_bd, edg_wd;

    logic        ent_hit, edg_hit, edg_qhit, scan_end;
    logic [17:0] sum;
    t_val        sat;

    assign o_ready       = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_boost_total = r_out;

    assign ent_hit  = r_pv && (r_rk == r_key) && (r_rf == r_tf) && (r_rx == r_tx);
    assign edg_hit  = r_pv && (r_gff == r_sf) && (r_gfx == r_sx)
                      && (r_gtf == r_tf) && (r_gtx == r_tx);
    assign edg_qhit = r_pv && (r_gff == r_wf) && (r_gfx == r_wx)
                      && (r_gtf == r_tf) && (r_gtx == r_tx);
    assign sum      = {1'b0, r_total} + {1'b0, r_gw};
    assign sat      = (sum > {2'b00, r_cap}) ? {1'b0, r_cap} : sum[16:0];

    always_comb begin
        n_state     = r_state;
        n_ridx      = r_ridx;
        n_pv        = 1'b0;
        n_pidx      = r_ridx;
        n_ent_cnt   = r_ent_cnt;
        n_ent_pos   = r_ent_pos;
        n_edg_cnt   = r_edg_cnt;
        n_edg_pos   = r_edg_pos;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        ent_we      = 1'b0;
        ent_bwe     = 1'b0;
        ent_wa      = r_pidx[ENT_AW-1:0];
        ent_bd      = r_rb + STEP_GAIN;
        edg_we      = 1'b0;
        edg_wwe     = 1'b0;
        edg_wa      = r_pidx[EDG_AW-1:0];
        edg_wd      = r_gw + STEP_GAIN;
        scan_end    = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_ridx = '0;
                if (i_valid) begin
                    case (i_opcode)
                        OP_OBSERVE, OP_ENGAGE: n_state = S_ESCAN;
                        OP_ATTRACT: begin
                            if (!(i_source_file == i_target_file
                                  && i_source_index == i_target_index))
                                n_state = S_GSCAN;
                        end
                        default: begin
                            if (i_first_of_query) begin
                                n_total = '0;
                                n_state = S_ESCAN;
                            end else if (i_has_shown) begin
                                n_state = S_GSCAN;
                            end else if (i_last_of_query) begin
                                n_state = S_EMIT;
                            end
                        end
                    endcase
                end
            end
            S_ESCAN: begin
                if (r_ridx < SCAN_W'(r_ent_cnt)) begin
                    n_pv   = 1'b1;
                    n_ridx = r_ridx + 1'b1;
                end
                scan_end = ent_hit || (!r_pv && r_ridx == SCAN_W'(r_ent_cnt));
                if (ent_hit) begin
                    if (r_op == OP_ENGAGE && r_rb < {1'b0, r_cap})
                        ent_bwe = 1'b1;
                    if (r_op == OP_BOOST)
                        n_total = (r_rb > {1'b0, r_cap}) ? {1'b0, r_cap} : r_rb;
                end else if (scan_end && r_op != OP_BOOST) begin
                    ent_we  = 1'b1;
                    ent_bwe = 1'b1;
                    ent_bd  = (r_op == OP_ENGAGE && r_cap != 16'd0) ? STEP_GAIN : '0;
                    if (r_ent_cnt < ENT_CW'(ENT_DEPTH)) begin
                        ent_wa    = r_ent_cnt[ENT_AW-1:0];
                        n_ent_cnt = r_ent_cnt + 1'b1;
                    end else begin
                        ent_wa    = r_ent_pos;
                        n_ent_pos = (r_ent_pos == ENT_AW'(ENT_DEPTH - 1)) ? '0
                                    : r_ent_pos + 1'b1;
                    end
                end
                if (scan_end) begin
                    n_pv   = 1'b0;
                    n_ridx = '0;
                    if (r_op != OP_BOOST)  n_state = S_IDLE;
                    else if (r_has)        n_state = S_GSCAN;
                    else if (r_last)       n_state = S_EMIT;
                    else                   n_state = S_IDLE;
                end
            end
            S_GSCAN: begin
                if (r_ridx < SCAN_W'(r_edg_cnt)) begin
                    n_pv   = 1'b1;
                    n_ridx = r_ridx + 1'b1;
                end
                if (r_op == OP_BOOST) begin
                    if (edg_qhit) n_total = sat;
                    scan_end = !r_pv && r_ridx == SCAN_W'(r_edg_cnt);
                end else begin
                    scan_end = edg_hit || (!r_pv && r_ridx == SCAN_W'(r_edg_cnt));
                    if (edg_hit) begin
                        edg_wwe = (r_gw < {1'b0, r_cap});
                    end else if (scan_end) begin
                        edg_we  = 1'b1;
                        edg_wwe = 1'b1;
                        edg_wd  = STEP_GAIN;
                        if (r_edg_cnt < EDG_CW'(EDG_DEPTH)) begin
                            edg_wa    = r_edg_cnt[EDG_AW-1:0];
                            n_edg_cnt = r_edg_cnt + 1'b1;
                        end else begin
                            edg_wa    = r_edg_pos;
                            n_edg_pos = (r_edg_pos == EDG_AW'(EDG_DEPTH - 1)) ? '0
                                        : r_edg_pos + 1'b1;
                        end
                    end
                end
                if (scan_end) begin
                    n_pv   = 1'b0;
                    n_ridx = '0;
                    n_state = (r_op == OP_BOOST && r_last) ? S_EMIT : S_IDLE;
                end
            end
            default: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out = (r_total > {1'b0, r_cap}) ? r_cap : r_total[15:0];
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= 16'd100;
            r_pv        <= 1'b0;
            r_ridx      <= '0;
            r_ent_cnt   <= '0;
            r_ent_pos   <= '0;
            r_edg_cnt   <= '0;
            r_edg_pos   <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pv        <= n_pv;
            r_ridx      <= n_ridx;
            r_ent_cnt   <= n_ent_cnt;
            r_ent_pos   <= n_ent_pos;
            r_edg_cnt   <= n_edg_cnt;
            r_edg_pos   <= n_edg_pos;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= n_pidx;
        r_out  <= n_out;
        if (i_valid && o_ready) begin
            r_op   <= i_opcode;
            r_key  <= i_query_key;
            r_tf   <= i_target_file;
            r_tx   <= i_target_index;
            r_sf   <= i_source_file;
            r_sx   <= i_source_index;
            r_wf   <= {24'd0, i_shown_word[31:24]};
            r_wx   <= {8'd0, i_shown_word[23:0]};
            r_has  <= i_has_shown;
            r_last <= i_last_of_query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_key[ent_wa]  <= r_key;
            ent_file[ent_wa] <= r_tf;
            ent_idx[ent_wa]  <= r_tx;
        end
        if (ent_bwe) ent_boost[ent_wa] <= ent_bd;
        r_rk <= ent_key[r_ridx[ENT_AW-1:0]];
        r_rf <= ent_file[r_ridx[ENT_AW-1:0]];
        r_rx <= ent_idx[r_ridx[ENT_AW-1:0]];
        r_rb <= ent_boost[r_ridx[ENT_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (edg_we) begin
            edg_ff[edg_wa] <= r_sf;
            edg_fx[edg_wa] <= r_sx;
            edg_tf[edg_wa] <= r_tf;
            edg_tx[edg_wa] <= r_tx;
        end
        if (edg_wwe) edg_w[edg_wa] <= edg_wd;
        r_gff <= edg_ff[r_ridx[EDG_AW-1:0]];
        r_gfx <= edg_fx[r_ridx[EDG_AW-1:0]];
        r_gtf <= edg_tf[r_ridx[EDG_AW-1:0]];
        r_gtx <= edg_tx[r_ridx[EDG_AW-1:0]];
        r_gw  <= edg_w[r_ridx[EDG_AW-1:0]];
    end

`include "affinity_table_with_fifo_replace_assert.svh"
    `AFT_ASSERT_NEXT(a_busy_after_scan_start, i_clk, i_rst_n, (i_valid && o_ready && (i_opcode == OP_OBSERVE || i_opcode == OP_ENGAGE)), (!o_ready))
    `AFT_ASSERT_NOW(a_ent_cnt_bound, i_clk, i_rst_n, 1'b1, (r_ent_cnt <= ENT_CW'(ENT_DEPTH)))
    `AFT_ASSERT_NOW(a_edg_cnt_bound, i_clk, i_rst_n, 1'b1, (r_edg_cnt <= EDG_CW'(EDG_DEPTH)))
    `AFT_ASSERT_NEXT(a_emit_sets_valid, i_clk, i_rst_n, (r_state == S_EMIT && (!r_out_valid || i_ready)), (o_valid))
endmodule

// ----- dv/affinity_checker.sv -----
// ----------------------------------------------------------------------------
// Affinity table checker
// Watches the config, request and result channels, keeps a shadow copy of the
// entry and edge tables, predicts each boost total and compares in order.
// ----------------------------------------------------------------------------
module affinity_checker import aft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_query_key,
    input  logic [31:0] i_target_file,
    input  logic [31:0] i_target_index,
    input  logic [31:0] i_source_file,
    input  logic [31:0] i_source_index,
    input  logic [31:0] i_shown_word,
    input  logic        i_has_shown,
    input  logic        i_first_of_query,
    input  logic        i_last_of_query,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_boost_total,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] cap;
    logic [63:0] ent_key   [ENT_DEPTH];
    logic [31:0] ent_file  [ENT_DEPTH];
    logic [31:0] ent_index [ENT_DEPTH];
    logic [16:0] ent_boost [ENT_DEPTH];
    int          ent_count, ent_pos;
    logic [31:0] edg_sf [EDG_DEPTH];
    logic [31:0] edg_sx [EDG_DEPTH];
    logic [31:0] edg_tf [EDG_DEPTH];
    logic [31:0] edg_tx [EDG_DEPTH];
    logic [16:0] edg_w  [EDG_DEPTH];
    int          edg_count, edg_pos;
    logic [16:0] running_total;
    logic [15:0] totals_q[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = totals_q.size();

    function automatic int find_entry(logic [63:0] k, logic [31:0] f, logic [31:0] x);
        for (int i = 0; i < ent_count; i++)
            if (ent_key[i] == k && ent_file[i] == f && ent_index[i] == x) return i;
        return -1;
    endfunction

    function automatic void add_total(logic [16:0] w);
        logic [17:0] s;
        s = running_total + w;
        running_total = (s > cap) ? {1'b0, cap} : s[16:0];
    endfunction

    task automatic apply_request();
        int s;
        logic [31:0] wf, wx;
        logic        hit;
        if (i_opcode == OP_OBSERVE || i_opcode == OP_ENGAGE) begin
            s = find_entry(i_query_key, i_target_file, i_target_index);
            if (s < 0) begin
                if (ent_count < ENT_DEPTH) begin
                    s = ent_count;
                    ent_count++;
                end else begin
                    s = ent_pos;
                    ent_pos = (ent_pos + 1) % ENT_DEPTH;
                end
                ent_key[s] = i_query_key;
                ent_file[s] = i_target_file;
                ent_index[s] = i_target_index;
                ent_boost[s] = '0;
            end
            if (i_opcode == OP_ENGAGE && ent_boost[s] < cap) ent_boost[s] += STEP_GAIN;
        end else if (i_opcode == OP_ATTRACT) begin
            if (!(i_source_file == i_target_file && i_source_index == i_target_index)) begin
                hit = 1'b0;
                for (int i = 0; i < edg_count && !hit; i++) begin
                    if (edg_sf[i] == i_source_file && edg_sx[i] == i_source_index &&
                        edg_tf[i] == i_target_file && edg_tx[i] == i_target_index) begin
                        hit = 1'b1;
                        if (edg_w[i] < cap) edg_w[i] += STEP_GAIN;
                    end
                end
                if (!hit) begin
                    if (edg_count < EDG_DEPTH) begin
                        s = edg_count;
                        edg_count++;
                    end else begin
                        s = edg_pos;
                        edg_pos = (edg_pos + 1) % EDG_DEPTH;
                    end
                    edg_sf[s] = i_source_file;
                    edg_sx[s] = i_source_index;
                    edg_tf[s] = i_target_file;
                    edg_tx[s] = i_target_index;
                    edg_w[s] = STEP_GAIN;
                end
            end
        end else begin
            if (i_first_of_query) begin
                running_total = '0;
                s = find_entry(i_query_key, i_target_file, i_target_index);
                if (s >= 0) add_total(ent_boost[s]);
            end
            if (i_has_shown) begin
                wf = {24'd0, i_shown_word[31:24]};
                wx = {8'd0, i_shown_word[23:0]};
                for (int i = 0; i < edg_count; i++)
                    if (edg_sf[i] == wf && edg_sx[i] == wx &&
                        edg_tf[i] == i_target_file && edg_tx[i] == i_target_index)
                        add_total(edg_w[i]);
            end
            if (i_last_of_query)
                totals_q.push_back((running_total > cap) ? cap : running_total[15:0]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cap = 16'd100;
            ent_count = 0;
            ent_pos = 0;
            edg_count = 0;
            edg_pos = 0;
            running_total = '0;
            totals_q.delete();
            fails = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (totals_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, i_boost_total);
                    fails++;
                end else begin
                    if (i_boost_total !== totals_q[0]) begin
                        $display("%0t: boost_total mismatch, expected %0d, actual %0d",
                                 $time, totals_q[0], i_boost_total);
                        fails++;
                    end
                    void'(totals_q.pop_front());
                end
            end
            if (i_valid && i_ready) apply_request();
            if (i_cfg_valid && i_cfg_ready) cap = i_cfg_data;
        end
    end
endmodule

// ----- dv/tb_affinity_table_with_fifo_replace.sv -----
// ----------------------------------------------------------------------------
// Affinity table testbench
// Directed and random requests over small key and id pools, several boost_cap
// settings, random stalls on both sides and a long result back-pressure phase.
// ----------------------------------------------------------------------------
module tb_affinity_table_with_fifo_replace;
    import aft_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = OP_OBSERVE;
    logic [63:0] query_key = '0;
    logic [31:0] target_file = '0, target_index = '0;
    logic [31:0] source_file = '0, source_index = '0;
    logic [31:0] shown_word = '0;
    logic        has_shown = 1'b0, first_q = 1'b0, last_q = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] boost_total;
    int          fail_count, pending;
    bit          hold_off = 1'b0;
    bit          quiet = 1'b0;

    always #5 clk = ~clk;

    affinity_table_with_fifo_replace uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready), .i_opcode(opcode),
        .i_query_key(query_key), .i_target_file(target_file),
        .i_target_index(target_index), .i_source_file(source_file),
        .i_source_index(source_index), .i_shown_word(shown_word),
        .i_has_shown(has_shown), .i_first_of_query(first_q),
        .i_last_of_query(last_q), .o_valid(out_valid), .i_ready(out_ready),
        .o_boost_total(boost_total)
    );

    affinity_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_ready(in_ready), .i_opcode(opcode),
        .i_query_key(query_key), .i_target_file(target_file),
        .i_target_index(target_index), .i_source_file(source_file),
        .i_source_index(source_index), .i_shown_word(shown_word),
        .i_has_shown(has_shown), .i_first_of_query(first_q),
        .i_last_of_query(last_q), .i_out_valid(out_valid),
        .i_out_ready(out_ready), .i_boost_total(boost_total),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Result side: random stall bursts, long hold-off on request.
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(logic [1:0] op, logic [63:0] k, logic [31:0] tf,
                                logic [31:0] tx, logic [31:0] sf, logic [31:0] sx,
                                logic [31:0] w, logic hs, logic fq, logic lq);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        opcode <= op;
        query_key <= k;
        target_file <= tf;
        target_index <= tx;
        source_file <= sf;
        source_index <= sx;
        shown_word <= w;
        has_shown <= hs;
        first_q <= fq;
        last_q <= lq;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_cap(logic [15:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Small pools so lookups hit; shown words map onto file < 256, index < 2^24.
    function automatic logic [31:0] pick_id(int n);
        return $urandom_range(0, n);
    endfunction

    task automatic random_request();
        logic [63:0] k;
        logic [31:0] tf, tx, sf, sx, w;
        int          sel, len;
        k  = (($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : 64'(pick_id(5)));
        tf = ($urandom_range(0, 9) == 0) ? $urandom : pick_id(3);
        tx = ($urandom_range(0, 9) == 0) ? $urandom : pick_id(3);
        sf = ($urandom_range(0, 9) == 0) ? $urandom : pick_id(3);
        sx = ($urandom_range(0, 9) == 0) ? $urandom : pick_id(3);
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            send_request(OP_OBSERVE, k, tf, tx, sf, sx, $urandom, 1'($urandom),
                         1'($urandom), 1'($urandom));
        end else if (sel < 4) begin
            send_request(OP_ENGAGE, k, tf, tx, sf, sx, $urandom, 1'($urandom),
                         1'($urandom), 1'($urandom));
        end else if (sel < 6) begin
            send_request(OP_ATTRACT, k, tf, tx, sf, sx, $urandom, 1'($urandom),
                         1'($urandom), 1'($urandom));
        end else if (sel < 9) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                w = ($urandom_range(0, 7) == 0) ? $urandom : {8'(pick_id(3)), 24'(pick_id(3))};
                send_request(OP_BOOST, k, tf, tx, sf, sx, w, $urandom_range(0, 5) != 0,
                             i == 0, i == len - 1);
            end
        end else begin
            send_request(OP_BOOST, k, tf, tx, sf, sx, $urandom, 1'($urandom),
                         1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_BOOST, '1, '1, '1, '0, '0, '0, 1'b0, 1'b1, 1'b1);
        send_request(OP_OBSERVE, '1, '1, '1, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        for (int i = 0; i < 6; i++)
            send_request(OP_ENGAGE, '1, '1, '1, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        send_request(OP_ATTRACT, '0, 5, 7, 5, 7, '0, 1'b0, 1'b0, 1'b0);
        for (int i = 0; i < 5; i++)
            send_request(OP_ATTRACT, '0, '1, '1, 32'hFF, 32'hFFFFFF, '0, 1'b0, 1'b0, 1'b0);
        send_request(OP_BOOST, '1, '1, '1, '0, '0, '1, 1'b1, 1'b1, 1'b0);
        send_request(OP_BOOST, '0, '1, '1, '0, '0, '1, 1'b1, 1'b0, 1'b1);
        send_request(OP_BOOST, 64'd9, 1, 2, '0, '0, '1, 1'b1, 1'b1, 1'b1);
        send_request(OP_BOOST, '1, '1, '1, '0, '0, '1, 1'b1, 1'b0, 1'b1);
        for (int i = 0; i < 70; i++)
            send_request(OP_ATTRACT, '0, 1, 1, i, 0, '0, 1'b0, 1'b0, 1'b0);
        for (int i = 0; i < 36; i++)
            send_request(OP_OBSERVE, 64'(i), 0, 0, '0, '0, '0, 1'b0, 1'b0, 1'b0);

        write_cap(16'd0);
        send_request(OP_BOOST, '1, '1, '1, '0, '0, '1, 1'b1, 1'b1, 1'b1);
        for (int i = 0; i < 35; i++) random_request();
        write_cap(16'hFFFF);
        for (int i = 0; i < 35; i++) random_request();
        write_cap(16'd30);
        for (int i = 0; i < 35; i++) random_request();

        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 25; i++) random_request();
                in_valid <= 1'b0;
            end
        join
        drain();

        write_cap(16'd100);
        for (int i = 0; i < 45; i++) random_request();
        quiet = 1'b1;
        for (int i = 0; i < 35; i++) random_request();

        drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule

// ----- affinity_table_with_fifo_replace.f -----
+incdir+src
src/aft_pkg.sv
src/affinity_table_with_fifo_replace.sv
dv/affinity_checker.sv
dv/tb_affinity_table_with_fifo_replace.sv
